[rtl/core/ualu_pkg.sv]
// Package for the unsigned ALU core: widths, operation codes and the queue entry type.
// No dependencies.
package ualu_pkg;
  localparam int unsigned DataWidth = 32;
  localparam int unsigned ShWidth = $clog2(DataWidth);
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned PtrWidth = $clog2(QueueDepth);
  localparam int unsigned DivSteps = DataWidth;
  localparam int unsigned DivCntWidth = $clog2(DivSteps + 1);

  typedef enum logic [3:0] {
    OpAddChk = 4'd0, OpAdd = 4'd1, OpSubChk = 4'd2, OpSub = 4'd3,
    OpMulChk = 4'd4, OpMul = 4'd5, OpDiv = 4'd6, OpRem = 4'd7,
    OpEq = 4'd8, OpGt = 4'd9, OpAnd = 4'd10, OpOr = 4'd11,
    OpXor = 4'd12, OpNot = 4'd13, OpShl = 4'd14, OpShr = 4'd15
  } op_e;

  // Operation class chosen by the front end.
  typedef enum logic [2:0] {
    ClsSimple = 3'b001, ClsMul = 3'b010, ClsDiv = 3'b100
  } cls_e;

  typedef struct packed {
    op_e                  op;
    cls_e                 cls;
    logic [DataWidth-1:0] a;
    logic [DataWidth-1:0] b;
  } entry_t;
endpackage

[rtl/core/ualu_front.sv]
// Front end of the unsigned ALU: accepts words, classifies them and queues them.
// Depends on ualu_pkg.
module ualu_front import ualu_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 stall_o,
  input  logic [3:0]           action_i,
  input  logic [DataWidth-1:0] operand_a_i,
  input  logic [DataWidth-1:0] operand_b_i,
  output logic                 q_valid_o,
  input  logic                 q_pop_i,
  output entry_t               q_entry_o
);
  entry_t                 mem_q [QueueDepth];
  logic [PtrWidth-1:0]    wr_q, wr_d, rd_q, rd_d;
  logic [PtrWidth:0]      cnt_q, cnt_d;
  logic                   push;
  logic                   pop;
  entry_t                 in_entry;
  cls_e                   cls;

  always_comb begin
    unique case (op_e'(action_i))
      OpMulChk, OpMul: cls = ClsMul;
      OpDiv, OpRem:    cls = ClsDiv;
      default:         cls = ClsSimple;
    endcase
  end

  assign in_entry = '{op: op_e'(action_i), cls: cls, a: operand_a_i, b: operand_b_i};
  assign stall_o = (cnt_q == (PtrWidth+1)'(QueueDepth));
  assign push = valid_i && !stall_o;
  assign q_valid_o = (cnt_q != '0);
  assign pop = q_pop_i && q_valid_o;
  assign q_entry_o = mem_q[rd_q];

  assign wr_d = push ? wr_q + 1'b1 : wr_q;
  assign rd_d = pop ? rd_q + 1'b1 : rd_q;
  assign cnt_d = cnt_q + {{PtrWidth{1'b0}}, push} - {{PtrWidth{1'b0}}, pop};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
      cnt_q <= '0;
    end else begin
      wr_q <= wr_d;
      rd_q <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= in_entry;
    end
  end
endmodule

[rtl/core/ualu_back.sv]
// Back end of the unsigned ALU: combinational simple ops, a registered multiplier
// and an iterative restoring divider, with a result register. Depends on ualu_pkg.
module ualu_back import ualu_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 q_valid_i,
  output logic                 q_pop_o,
  input  entry_t               q_entry_i,
  output logic                 valid_o,
  input  logic                 stall_i,
  output logic [DataWidth-1:0] result_value_o,
  output logic                 error_flag_o
);
  localparam int unsigned Dw2 = 2 * DataWidth;

  // Output register.
  logic                 out_vld_q;
  logic [DataWidth-1:0] out_val_q;
  logic                 out_err_q;
  logic                 out_free;
  logic                 out_load;

  // Multiplier stage.
  logic                 mul_busy_q;
  logic                 mul_chk_q;
  logic [Dw2-1:0]       prod_q;

  // Divider.
  logic                   div_busy_q, div_done_q;
  logic                   div_rem_q, div_zero_q;
  logic [DivCntWidth-1:0] div_cnt_q;
  logic [DataWidth-1:0]   div_quo_q, div_b_q;
  logic [DataWidth-1:0]   div_r_q;
  logic [DataWidth+1:0]   trial;

  logic                   busy;
  logic                   take;
  logic [DataWidth:0]     sum_ext, dif_ext;
  logic [DataWidth-1:0]   simple_val, a, b;
  logic                   simple_err;
  logic                   big_sh;

  assign out_free = !out_vld_q || !stall_i;
  assign busy = mul_busy_q || div_busy_q;
  assign take = q_valid_i && !busy && out_free;
  assign q_pop_o = take;
  assign a = q_entry_i.a;
  assign b = q_entry_i.b;
  assign sum_ext = {1'b0, a} + {1'b0, b};
  assign dif_ext = {1'b0, a} - {1'b0, b};
  assign big_sh = (b > DataWidth'(DataWidth - 1));
  assign out_load = (take && q_entry_i.cls == ClsSimple) || (mul_busy_q && out_free) ||
                    (div_busy_q && div_done_q && out_free);

  always_comb begin
    simple_err = 1'b0;
    unique case (q_entry_i.op)
      OpAddChk: begin
        simple_val = sum_ext[DataWidth-1:0];
        simple_err = sum_ext[DataWidth];
      end
      OpAdd:    simple_val = sum_ext[DataWidth-1:0];
      OpSubChk: begin
        simple_val = dif_ext[DataWidth-1:0];
        simple_err = dif_ext[DataWidth];
      end
      OpSub:    simple_val = dif_ext[DataWidth-1:0];
      OpEq:     simple_val = DataWidth'(a == b);
      OpGt:     simple_val = DataWidth'(a > b);
      OpAnd:    simple_val = a & b;
      OpOr:     simple_val = a | b;
      OpXor:    simple_val = a ^ b;
      OpNot:    simple_val = ~a;
      OpShl:    simple_val = big_sh ? '0 : a << b[ShWidth-1:0];
      OpShr:    simple_val = big_sh ? '0 : a >> b[ShWidth-1:0];
      default:  simple_val = '0;
    endcase
  end

  // The shifted partial remainder can reach 33 bits, so the trial needs a separate sign bit.
  assign trial = {1'b0, div_r_q, div_quo_q[DataWidth-1]} - {2'b00, div_b_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      mul_busy_q <= 1'b0;
      div_busy_q <= 1'b0;
      div_done_q <= 1'b0;
      div_cnt_q <= '0;
    end else begin
      if (out_load) out_vld_q <= 1'b1;
      else if (!stall_i) out_vld_q <= 1'b0;
      if (take) begin
        unique case (q_entry_i.cls)
          ClsMul: mul_busy_q <= 1'b1;
          ClsDiv: begin
            div_busy_q <= 1'b1;
            div_done_q <= (b == '0);
            div_cnt_q <= '0;
          end
          default: ;
        endcase
      end
      if (mul_busy_q && out_free) begin
        mul_busy_q <= 1'b0;
      end
      if (div_busy_q && !div_done_q) begin
        div_cnt_q <= div_cnt_q + 1'b1;
        if (div_cnt_q == DivCntWidth'(DivSteps - 1)) div_done_q <= 1'b1;
      end
      if (div_busy_q && div_done_q && out_free) begin
        div_busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      unique case (q_entry_i.cls)
        ClsMul: begin
          prod_q <= a * b;
          mul_chk_q <= (q_entry_i.op == OpMulChk);
        end
        ClsDiv: begin
          div_rem_q <= (q_entry_i.op == OpRem);
          div_zero_q <= (b == '0);
          div_b_q <= b;
          div_quo_q <= a;
          div_r_q <= '0;
        end
        default: begin
          out_val_q <= simple_val;
          out_err_q <= simple_err;
        end
      endcase
    end
    if (mul_busy_q && out_free) begin
      out_val_q <= prod_q[DataWidth-1:0];
      out_err_q <= mul_chk_q && (prod_q[Dw2-1:DataWidth] != '0);
    end
    // One quotient bit per cycle; the dividend shifts out as quotient bits shift in.
    if (div_busy_q && !div_done_q) begin
      if (!trial[DataWidth+1]) begin
        div_r_q <= trial[DataWidth-1:0];
        div_quo_q <= {div_quo_q[DataWidth-2:0], 1'b1};
      end else begin
        div_r_q <= {div_r_q[DataWidth-2:0], div_quo_q[DataWidth-1]};
        div_quo_q <= {div_quo_q[DataWidth-2:0], 1'b0};
      end
    end
    if (div_busy_q && div_done_q && out_free) begin
      out_err_q <= div_zero_q;
      out_val_q <= div_zero_q ? '0 :
                   (div_rem_q ? div_r_q : div_quo_q);
    end
  end

  assign valid_o = out_vld_q;
  assign result_value_o = out_val_q;
  assign error_flag_o = out_err_q;
endmodule

[rtl/core/unsigned_alu_with_error_flags_core.sv]
// Unsigned ALU core. Add, sub, compare, logic and shifts: one word per cycle while
// the output is not stalled. Mul: no new word until the product of the registered
// multiplier stage is in the result register. Div and rem: radix-2 divider
// (one quotient bit per cycle), no new word until done; zero divisors skip steps.
// Reset (rst_ni, asynchronous, active low) empties the queue and clears all valids.
module unsigned_alu_with_error_flags_core import ualu_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 stall_o,
  input  logic [3:0]           action_i,
  input  logic [DataWidth-1:0] operand_a_i,
  input  logic [DataWidth-1:0] operand_b_i,
  output logic                 valid_o,
  input  logic                 stall_i,
  output logic [DataWidth-1:0] result_value_o,
  output logic                 error_flag_o
);
  logic   q_valid;
  logic   q_pop;
  entry_t q_entry;

  ualu_front u_front (
    .clk_i, .rst_ni, .valid_i, .stall_o, .action_i, .operand_a_i, .operand_b_i,
    .q_valid_o(q_valid), .q_pop_i(q_pop), .q_entry_o(q_entry)
  );

  ualu_back u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_pop_o(q_pop), .q_entry_i(q_entry),
    .valid_o, .stall_i, .result_value_o, .error_flag_o
  );

  a_pop_needs_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid) else $error("queue popped while empty");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> valid_o && $stable(result_value_o) && $stable(error_flag_o))
    else $error("stalled result changed");
  a_cmp_bool: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop && (q_entry.op == OpEq || q_entry.op == OpGt)
    |=> result_value_o[DataWidth-1:1] == '0) else $error("compare result not 0 or 1");
endmodule
